@@ src/isa_pkg.sv @@
`default_nettype none

package isa_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_ERASE  = 2'd2;
    localparam logic [1:0] OP_INSERT = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Control broadcast to every cell of the row for one item.
    typedef struct packed {
        logic              ins;
        logic              ers;
        logic              wr;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] value;
    } isa_cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/indexed_shift_array.sv @@
`default_nettype none

// Packed list of up to 64 signed 32-bit words held in a row of register cells.
// Each item reads, overwrites, erases or inserts at an index and returns one
// result with the read data, the entry count, an empty flag and a status.
// An insert shifts the cells above the index up by one place and an erase shifts
// the cells at and above it down, in the cycle the item is accepted, and the
// result sits in an output register, so a new item is taken in every cycle in
// which the result register is free or being emptied. No clearing pass is needed after reset.

module indexed_shift_array
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    opcode,
    input  wire logic [isa_pkg::IDX_W-1:0]     index,
    input  wire logic signed [31:0]            write_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [31:0]                 read_value,
    output logic      [isa_pkg::CNT_W-1:0]     entry_count,
    output logic                               is_empty,
    output logic      [1:0]                    status
);
    import isa_pkg::*;

    logic                 accept;
    logic                 bad_index;
    logic                 full;
    logic                 good;
    isa_cell_ctrl_t       ctrl;
    logic [DATA_W-1:0]    cell_entry [DEPTH];
    logic [DATA_W-1:0]    cell_rd    [DEPTH];
    logic [DATA_W-1:0]    rd_or;
    logic [CNT_W-1:0]     ext_index;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 out_valid_reg;
    logic [DATA_W-1:0]    read_value_reg;
    logic [DATA_W-1:0]    read_value_next;
    logic [CNT_W-1:0]     entry_count_reg;
    logic                 is_empty_reg;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    assign ext_index = CNT_W'(index);

    always_comb
    begin
        if (opcode == OP_INSERT)
        begin
            bad_index = (ext_index > count_reg);
        end
        else
        begin
            bad_index = (ext_index >= count_reg);
        end
        full = (opcode == OP_INSERT) && (count_reg == CNT_W'(DEPTH));
        good = ~bad_index & ~full;
    end

    assign ctrl.ins   = accept & good & (opcode == OP_INSERT);
    assign ctrl.ers   = accept & good & (opcode == OP_ERASE);
    assign ctrl.wr    = accept & good & (opcode == OP_WRITE);
    assign ctrl.index = index;
    assign ctrl.value = write_value;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DATA_W-1:0] prev_in;
        logic [DATA_W-1:0] next_in;

        if (g == 0)
        begin : g_first
            assign prev_in = write_value;
        end
        else
        begin : g_mid_lo
            assign prev_in = cell_entry[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign next_in = cell_entry[g];
        end
        else
        begin : g_mid_hi
            assign next_in = cell_entry[g+1];
        end

        isa_cell u_cell
        (
            .clk        (clk),
            .pos        (IDX_W'(g)),
            .ctrl       (ctrl),
            .prev_entry (prev_in),
            .next_entry (next_in),
            .entry      (cell_entry[g]),
            .rd_data    (cell_rd[g])
        );
    end

    // At most one cell matches the index, so an OR over the row selects it.
    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        read_value_next = '0;
        status_next     = ST_DONE;
        if (bad_index)
        begin
            read_value_next = '1;
            status_next     = ST_BAD;
        end
        else if (full)
        begin
            status_next = ST_FULL;
        end
        else
        begin
            unique case (opcode)
                OP_READ:   read_value_next = rd_or;
                OP_WRITE:  count_next = count_reg;
                OP_ERASE:  count_next = count_reg - 1'b1;
                OP_INSERT: count_next = count_reg + 1'b1;
                default:   count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg  <= read_value_next;
            entry_count_reg <= count_next;
            is_empty_reg    <= (count_next == '0);
            status_reg      <= status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;
    assign is_empty    = is_empty_reg;
    assign status      = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted insert did not grow the list");

    a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !good |=> count_reg == $past(count_reg) && status_reg != ST_DONE)
        else $error("refused item changed the list or reported done");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        accept && status_next == ST_FULL |-> count_reg == CNT_W'(DEPTH))
        else $error("full status while list not full");

    a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg && entry_count_reg == count_reg)
        else $error("result count does not match list count");

endmodule

`default_nettype wire

@@ src/isa_cell.sv @@
`default_nettype none

module isa_cell
(
    input  wire logic                          clk,
    input  wire logic [isa_pkg::IDX_W-1:0]     pos,
    input  wire isa_pkg::isa_cell_ctrl_t       ctrl,
    input  wire logic [isa_pkg::DATA_W-1:0]    prev_entry,
    input  wire logic [isa_pkg::DATA_W-1:0]    next_entry,
    output logic      [isa_pkg::DATA_W-1:0]    entry,
    output logic      [isa_pkg::DATA_W-1:0]    rd_data
);
    import isa_pkg::*;

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic              hit;
    logic              above;

    assign hit   = (pos == ctrl.index);
    assign above = (pos > ctrl.index);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (above)
            begin
                entry_next = prev_entry;
            end
            else if (hit)
            begin
                entry_next = ctrl.value;
            end
        end
        else if (ctrl.ers)
        begin
            // The cell at the erased place and every cell above it pull from above.
            if (above || hit)
            begin
                entry_next = next_entry;
            end
        end
        else if (ctrl.wr && hit)
        begin
            entry_next = ctrl.value;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry   = entry_reg;
    assign rd_data = hit ? entry_reg : '0;

endmodule

`default_nettype wire
